// ----- hw/rtl/sspfa_pkg.sv -----
// Shared types, constants and helpers of the soft-sphere pair force accumulator.
`default_nettype none
package sspfa_pkg;

   // accumulated force word, signed Q32.16
   typedef logic signed [47:0] force_type;
   // one force contribution, signed Q35.16
   typedef logic signed [50:0] contrib_type;

   // action codes of an input word
   localparam logic ACTION_ACCUM = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // register indexes on the configuration port
   localparam logic [1:0] REG_COUNT        = 2'd0;
   localparam logic [1:0] REG_PART_STIFF   = 2'd1;
   localparam logic [1:0] REG_SHELL_STIFF  = 2'd2;
   localparam logic [1:0] REG_SHELL_RADIUS = 2'd3;

   // last step of each bit-serial unit
   localparam logic [5:0] MUL_LAST  = 6'd32;
   localparam logic [5:0] SQRT_LAST = 6'd32;
   localparam logic [5:0] DIV_LAST  = 6'd31;

   // saturating add of a contribution to a stored force
   function automatic force_type sat_add(force_type old_v, contrib_type d);
      logic signed [51:0] sum;
      force_type          res;
      sum = {{4{old_v[47]}}, old_v} + {d[50], d};
      if ((sum[51:47] == 5'b00000) || (sum[51:47] == 5'b11111)) begin
         res = sum[47:0];
      end else if (sum[51]) begin
         res = {1'b1, 47'd0};
      end else begin
         res = {1'b0, {47{1'b1}}};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/soft_sphere_pair_force_accumulator.sv -----
// Top level of the soft-sphere pair force accumulator.
// An accumulate word holds off the next input word until its force is stored:
// three lanes (x, y, z) share a sequencer that runs a bit-serial shift-add
// multiplier for the squares, a sum of the squares, a two-bits-per-step square
// root, a shift-add multiply by the radius sum, a one-bit-per-step divider, a
// sign step and a last shift-add multiply by the stiffness, with a zero-distance
// test after the square root, then a read-modify-write on the force store of
// the first particle and, when the second particle is real, one of the second.
// A coincident pair frees the input after the zero-distance test, and a pair
// whose first particle is not real is dropped on acceptance. A read word is read
// from the store and then waits until the result side is free.
// After reset the store is cleared entry by entry, during which req_stall stays
// high; configuration writes are taken throughout.
`default_nettype none
module soft_sphere_pair_force_accumulator #(
   parameter int MAX_PARTICLES = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input words
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic [11:0]        req_first_index,
   input  wire logic [11:0]        req_second_index,
   input  wire logic signed [31:0] req_first_x,
   input  wire logic signed [31:0] req_first_y,
   input  wire logic signed [31:0] req_first_z,
   input  wire logic signed [31:0] req_second_x,
   input  wire logic signed [31:0] req_second_y,
   input  wire logic signed [31:0] req_second_z,
   input  wire logic [30:0]        req_first_radius,
   input  wire logic [30:0]        req_second_radius,
   // result words
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [11:0]             rsp_particle_index,
   output logic signed [47:0]      rsp_force_x,
   output logic signed [47:0]      rsp_force_y,
   output logic signed [47:0]      rsp_force_z,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int AW = $clog2(MAX_PARTICLES);
   localparam logic [17:0] MAX_W = 18'(MAX_PARTICLES);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_PARTICLES - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_ROOT  = 4'd5;
   localparam logic [3:0] S_MULA  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_MVAL  = 4'd8;
   localparam logic [3:0] S_MULK  = 4'd9;
   localparam logic [3:0] S_RDI   = 4'd10;
   localparam logic [3:0] S_WRI   = 4'd11;
   localparam logic [3:0] S_RDJ   = 4'd12;
   localparam logic [3:0] S_WRJ   = 4'd13;
   localparam logic [3:0] S_RDR   = 4'd14;
   localparam logic [3:0] S_RDO   = 4'd15;

   // configuration registers
   logic [12:0] count_ff, count_in;
   logic [31:0] pstiff_ff, pstiff_in;
   logic [31:0] sstiff_ff, sstiff_in;
   logic [30:0] srad_ff, srad_in;

   // sequencer
   logic [3:0]    state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;

   // word held while it is worked on
   logic [11:0] i_ff, i_in;
   logic [11:0] j_ff, j_in;
   logic        jreal_ff, jreal_in;
   logic        irange_ff, irange_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] k_ff, k_in;

   // lanes x, y, z
   logic [32:0]              mr_ff [3];
   logic [32:0]              mr_in [3];
   logic                     rneg_ff [3];
   logic                     rneg_in [3];
   logic                     fneg_ff [3];
   logic                     fneg_in [3];
   logic [32:0]              mcand_ff [3];
   logic [32:0]              mcand_in [3];
   logic [65:0]              mp_ff [3];
   logic [65:0]              mp_in [3];
   logic [33:0]              drem_ff [3];
   logic [33:0]              drem_in [3];
   logic [31:0]              dlo_ff [3];
   logic [31:0]              dlo_in [3];
   sspfa_pkg::contrib_type   f_ff [3];
   sspfa_pkg::contrib_type   f_in [3];
   sspfa_pkg::contrib_type   fn_ff [3];
   sspfa_pkg::contrib_type   fn_in [3];

   // square root
   logic [65:0] rad_ff, rad_in;
   logic [32:0] root_ff, root_in;
   logic [35:0] srem_ff, srem_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [11:0]            rsp_index_ff, rsp_index_in;
   sspfa_pkg::force_type   rsp_force_ff [3];
   sspfa_pkg::force_type   rsp_force_in [3];

   // store port
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [143:0]  ram_wdata, ram_rdata;

   // per-lane step logic
   logic signed [31:0]     pa [3];
   logic signed [31:0]     pb [3];
   logic [32:0]            rd [3];
   logic [32:0]            rmag [3];
   logic [33:0]            madd [3];
   logic [65:0]            mstep [3];
   logic [33:0]            drem2 [3];
   logic                   dge [3];
   logic [32:0]            qx [3];
   logic                   qlt [3];
   logic [32:0]            mval [3];
   logic [50:0]            fpos [3];
   sspfa_pkg::contrib_type fcomb [3];
   sspfa_pkg::force_type   old_f [3];

   logic [35:0] srem2, strial;
   logic        sge;
   logic [16:0] i_ext, j_ext;
   logic [AW-1:0] i_addr, j_addr;
   logic        accept, cfg_write;
   logic        req_irange, req_ireal, req_jreal, rsp_free;

   sspfa_ram #(
      .WIDTH (144),
      .DEPTH (MAX_PARTICLES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      count_in  = count_ff;
      pstiff_in = pstiff_ff;
      sstiff_in = sstiff_ff;
      srad_in   = srad_ff;
      prdata    = 32'd0;
      unique case (paddr[3:2])
         sspfa_pkg::REG_COUNT: begin
            prdata = {19'd0, count_ff};
            if (cfg_write) count_in = pwdata[12:0];
         end
         sspfa_pkg::REG_PART_STIFF: begin
            prdata = pstiff_ff;
            if (cfg_write) pstiff_in = pwdata;
         end
         sspfa_pkg::REG_SHELL_STIFF: begin
            prdata = sstiff_ff;
            if (cfg_write) sstiff_in = pwdata;
         end
         sspfa_pkg::REG_SHELL_RADIUS: begin
            prdata = {1'b0, srad_ff};
            if (cfg_write) srad_in = pwdata[30:0];
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   // index checks and store addresses
   assign req_irange = ({6'd0, req_first_index} < MAX_W);
   assign req_ireal  = req_irange && ({1'b0, req_first_index} < count_ff);
   assign req_jreal  = ({6'd0, req_second_index} < MAX_W)
                       && ({1'b0, req_second_index} < count_ff);
   assign i_ext  = {5'd0, i_ff};
   assign j_ext  = {5'd0, j_ff};
   assign i_addr = i_ext[AW-1:0];
   assign j_addr = j_ext[AW-1:0];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign pa[0] = req_first_x;
   assign pa[1] = req_first_y;
   assign pa[2] = req_first_z;
   assign pb[0] = req_second_x;
   assign pb[1] = req_second_y;
   assign pb[2] = req_second_z;

   // lane datapath: difference, shift-add step, divide step, force sign
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rd[l]    = {pa[l][31], pa[l]} - {pb[l][31], pb[l]};
         rmag[l]  = rd[l][32] ? (33'd0 - rd[l]) : rd[l];
         madd[l]  = {1'b0, mp_ff[l][65:33]} + (mp_ff[l][0] ? {1'b0, mcand_ff[l]} : 34'd0);
         mstep[l] = {madd[l], mp_ff[l][32:1]};
         drem2[l] = {drem_ff[l][32:0], dlo_ff[l][31]};
         dge[l]   = (drem2[l] >= {1'b0, root_ff});
         qx[l]    = {1'b0, dlo_ff[l]};
         qlt[l]   = (qx[l] < mr_ff[l]);
         mval[l]  = qlt[l] ? (mr_ff[l] - qx[l]) : (qx[l] - mr_ff[l]);
         fpos[l]  = {1'b0, mp_ff[l][65:16]};
         fcomb[l] = fneg_ff[l] ? -$signed(fpos[l]) : $signed(fpos[l]);
         old_f[l] = ram_rdata[48*l +: 48];
      end
   end

   // square-root step, two radicand bits per cycle
   assign srem2  = {srem_ff[33:0], rad_ff[65:64]};
   assign strial = {1'b0, root_ff, 2'b01};
   assign sge    = (srem2 >= strial);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + 6'd1;
      clr_in       = clr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jreal_in     = jreal_ff;
      irange_in    = irange_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = i_addr;
      ram_raddr    = i_addr;
      ram_wdata    = 144'd0;
      for (int l = 0; l < 3; l++) begin
         mr_in[l]        = mr_ff[l];
         rneg_in[l]      = rneg_ff[l];
         fneg_in[l]      = fneg_ff[l];
         mcand_in[l]     = mcand_ff[l];
         mp_in[l]        = mp_ff[l];
         drem_in[l]      = drem_ff[l];
         dlo_in[l]       = dlo_ff[l];
         f_in[l]         = f_ff[l];
         fn_in[l]        = fn_ff[l];
         rsp_force_in[l] = rsp_force_ff[l];
      end

      unique case (state_ff)
         // zero the store after reset
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) state_in = S_IDLE;
         end
         // take a word
         S_IDLE: begin
            if (accept) begin
               i_in      = req_first_index;
               j_in      = req_second_index;
               irange_in = req_irange;
               jreal_in  = req_jreal;
               a_in      = {1'b0, req_first_radius}
                           + {1'b0, (req_jreal ? req_second_radius : srad_ff)};
               k_in      = req_jreal ? pstiff_ff : sstiff_ff;
               cnt_in    = 6'd0;
               for (int l = 0; l < 3; l++) begin
                  mr_in[l]    = rmag[l];
                  rneg_in[l]  = rd[l][32];
                  mcand_in[l] = rmag[l];
                  mp_in[l]    = {33'd0, rmag[l]};
               end
               if (req_action == sspfa_pkg::ACTION_READ) begin
                  state_in = S_RDR;
               end else if (req_ireal) begin
                  state_in = S_SQ;
               end
            end
         end
         // squares of the differences
         S_SQ: begin
            for (int l = 0; l < 3; l++) mp_in[l] = mstep[l];
            if (cnt_ff == sspfa_pkg::MUL_LAST) begin
               state_in = S_SUM;
               cnt_in   = 6'd0;
            end
         end
         // sum of squares, x and y first, then z
         S_SUM: begin
            if (cnt_ff == 6'd0) begin
               rad_in = mp_ff[0] + mp_ff[1];
            end else begin
               rad_in   = rad_ff + mp_ff[2];
               root_in  = 33'd0;
               srem_in  = 36'd0;
               cnt_in   = 6'd0;
               state_in = S_SQRT;
            end
         end
         // distance
         S_SQRT: begin
            rad_in  = {rad_ff[63:0], 2'b00};
            srem_in = sge ? (srem2 - strial) : srem2;
            root_in = {root_ff[31:0], sge};
            if (cnt_ff == sspfa_pkg::SQRT_LAST) state_in = S_ROOT;
         end
         // coincident pair adds nothing
         S_ROOT: begin
            cnt_in = 6'd0;
            for (int l = 0; l < 3; l++) begin
               mcand_in[l] = {1'b0, a_ff};
               mp_in[l]    = {33'd0, mr_ff[l]};
            end
            state_in = (root_ff == 33'd0) ? S_IDLE : S_MULA;
         end
         // radius sum times |r|
         S_MULA: begin
            for (int l = 0; l < 3; l++) mp_in[l] = mstep[l];
            if (cnt_ff == sspfa_pkg::MUL_LAST) begin
               cnt_in = 6'd0;
               for (int l = 0; l < 3; l++) begin
                  drem_in[l] = mstep[l][65:32];
                  dlo_in[l]  = mstep[l][31:0];
               end
               state_in = S_DIV;
            end
         end
         // quotient by the distance, one bit a cycle
         S_DIV: begin
            for (int l = 0; l < 3; l++) begin
               drem_in[l] = dge[l] ? (drem2[l] - {1'b0, root_ff}) : drem2[l];
               dlo_in[l]  = {dlo_ff[l][30:0], dge[l]};
            end
            if (cnt_ff == sspfa_pkg::DIV_LAST) state_in = S_MVAL;
         end
         // overlap term and its sign
         S_MVAL: begin
            cnt_in = 6'd0;
            for (int l = 0; l < 3; l++) begin
               fneg_in[l]  = rneg_ff[l] ^ qlt[l];
               mcand_in[l] = mval[l];
               mp_in[l]    = {33'd0, 1'b0, k_ff};
            end
            state_in = S_MULK;
         end
         // times stiffness
         S_MULK: begin
            for (int l = 0; l < 3; l++) mp_in[l] = mstep[l];
            if (cnt_ff == sspfa_pkg::MUL_LAST) state_in = S_RDI;
         end
         // first particle update
         S_RDI: begin
            ram_re = 1'b1;
            for (int l = 0; l < 3; l++) f_in[l] = fcomb[l];
            state_in = S_WRI;
         end
         S_WRI: begin
            ram_we = 1'b1;
            for (int l = 0; l < 3; l++) begin
               ram_wdata[48*l +: 48] = sspfa_pkg::sat_add(old_f[l], f_ff[l]);
               fn_in[l] = -f_ff[l];
            end
            state_in = jreal_ff ? S_RDJ : S_IDLE;
         end
         // second particle gets the opposite force
         S_RDJ: begin
            ram_re    = 1'b1;
            ram_raddr = j_addr;
            state_in  = S_WRJ;
         end
         S_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_addr;
            for (int l = 0; l < 3; l++) begin
               ram_wdata[48*l +: 48] = sspfa_pkg::sat_add(old_f[l], fn_ff[l]);
            end
            state_in = S_IDLE;
         end
         // read and clear
         S_RDR: begin
            ram_re   = irange_ff;
            state_in = S_RDO;
         end
         S_RDO: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = i_ff;
               ram_we       = irange_ff;
               for (int l = 0; l < 3; l++) begin
                  rsp_force_in[l] = irange_ff ? old_f[l] : 48'sd0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 13'd0;
         pstiff_ff    <= 32'd0;
         sstiff_ff    <= 32'd0;
         srad_ff      <= 31'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         pstiff_ff    <= pstiff_in;
         sstiff_ff    <= sstiff_in;
         srad_ff      <= srad_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      jreal_ff     <= jreal_in;
      irange_ff    <= irange_in;
      a_ff         <= a_in;
      k_ff         <= k_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      rsp_index_ff <= rsp_index_in;
      for (int l = 0; l < 3; l++) begin
         mr_ff[l]        <= mr_in[l];
         rneg_ff[l]      <= rneg_in[l];
         fneg_ff[l]      <= fneg_in[l];
         mcand_ff[l]     <= mcand_in[l];
         mp_ff[l]        <= mp_in[l];
         drem_ff[l]      <= drem_in[l];
         dlo_ff[l]       <= dlo_in[l];
         f_ff[l]         <= f_in[l];
         fn_ff[l]        <= fn_in[l];
         rsp_force_ff[l] <= rsp_force_in[l];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_particle_index = rsp_index_ff;
   assign rsp_force_x        = rsp_force_ff[0];
   assign rsp_force_y        = rsp_force_ff[1];
   assign rsp_force_z        = rsp_force_ff[2];

endmodule
`default_nettype wire

// ----- hw/rtl/sspfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sspfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sspfa_checker.sv -----
// Port-level checks of the soft-sphere pair force accumulator, bound to the top level.
`default_nettype none
module sspfa_checker #(
   parameter int MAX_PARTICLES = 4096
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [11:0]        rsp_particle_index,
   input wire logic signed [47:0] rsp_force_x,
   input wire logic signed [47:0] rsp_force_y,
   input wire logic signed [47:0] rsp_force_z
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its force
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_force_x) && $stable(rsp_force_y)
                                 && $stable(rsp_force_z))
      else $error("result word changed while stalled");

   // the store clear holds off input words right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken during store clear");

   // a read beyond the store reports zero force
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_particle_index) >= 32'(MAX_PARTICLES))
      |-> (rsp_force_x == 48'sd0) && (rsp_force_y == 48'sd0) && (rsp_force_z == 48'sd0))
      else $error("out-of-range read gave non-zero force");

endmodule

bind soft_sphere_pair_force_accumulator sspfa_checker #(
   .MAX_PARTICLES (MAX_PARTICLES)
) u_sspfa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_particle_index (rsp_particle_index),
   .rsp_force_x        (rsp_force_x),
   .rsp_force_y        (rsp_force_y),
   .rsp_force_z        (rsp_force_z)
);
`default_nettype wire

// ----- tb/sv/soft_sphere_pair_force_accumulator_checker.sv -----
// Checker of the soft-sphere pair force accumulator: predicts the force stores and checks reads.
`default_nettype none
module soft_sphere_pair_force_accumulator_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_action,
   input  wire logic [11:0]        req_first_index,
   input  wire logic [11:0]        req_second_index,
   input  wire logic signed [31:0] req_first_x,
   input  wire logic signed [31:0] req_first_y,
   input  wire logic signed [31:0] req_first_z,
   input  wire logic signed [31:0] req_second_x,
   input  wire logic signed [31:0] req_second_y,
   input  wire logic signed [31:0] req_second_z,
   input  wire logic [30:0]        req_first_radius,
   input  wire logic [30:0]        req_second_radius,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [11:0]        rsp_particle_index,
   input  wire logic signed [47:0] rsp_force_x,
   input  wire logic signed [47:0] rsp_force_y,
   input  wire logic signed [47:0] rsp_force_z,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   input  wire logic               pready,
   output int                      fail_count,
   output int                      reads_due
);

   localparam int STORE_DEPTH = 4096;
   localparam longint FORCE_MAX = 64'sd140737488355327;
   localparam longint FORCE_MIN = -64'sd140737488355328;

   typedef struct {
      logic [11:0]          index;
      sspfa_pkg::force_type fx;
      sspfa_pkg::force_type fy;
      sspfa_pkg::force_type fz;
   } read_word_type;

   // predicted register copies and force stores
   logic [12:0]   real_count;
   logic [31:0]   pair_k;
   logic [31:0]   shell_k;
   logic [30:0]   shell_rad;
   longint        acc_x [STORE_DEPTH];
   longint        acc_y [STORE_DEPTH];
   longint        acc_z [STORE_DEPTH];
   read_word_type pending_reads[$];

   assign reads_due = pending_reads.size();

   // floor square root of the sum of squares
   function automatic logic [35:0] floor_sqrt(logic [67:0] sumsq);
      logic [71:0] root;
      logic [71:0] trial;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (72'd1 << b);
         if (trial * trial <= {4'd0, sumsq}) root = trial;
      end
      return root[35:0];
   endfunction

   // one component of -k*(1-A/s)*r, truncated toward zero
   function automatic longint spring_term(logic [31:0] k, logic [63:0] a, longint r,
                                          logic [35:0] s);
      logic [127:0] prod;
      logic [63:0]  mr;
      logic [63:0]  q;
      logic [63:0]  m;
      logic [63:0]  p;
      bit           neg;
      mr = (r < 0) ? 64'(-r) : 64'(r);
      prod = 128'(a) * 128'(mr);
      q = 64'(prod / 128'(s));
      neg = (r < 0);
      if (q >= mr) begin
         m = q - mr;
      end else begin
         m = mr - q;
         neg = !neg;
      end
      prod = 128'(m) * 128'(k);
      p = prod[63:0] >> 16;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint clamp_add(longint old_v, longint d);
      longint sum;
      sum = old_v + d;
      if (sum > FORCE_MAX) return FORCE_MAX;
      if (sum < FORCE_MIN) return FORCE_MIN;
      return sum;
   endfunction

   // apply one accepted input word to the predicted stores
   task automatic predict_word();
      longint        rx, ry, rz, fx, fy, fz;
      logic [67:0]   sumsq;
      logic [35:0]   span;
      logic [63:0]   rad_sum;
      logic [31:0]   k;
      int            cnt;
      int            i;
      int            j;
      read_word_type rw;
      cnt = (real_count < STORE_DEPTH) ? int'(real_count) : STORE_DEPTH;
      i = int'(req_first_index);
      j = int'(req_second_index);
      if (req_action == sspfa_pkg::ACTION_READ) begin
         rw.index = req_first_index;
         rw.fx = acc_x[i][47:0];
         rw.fy = acc_y[i][47:0];
         rw.fz = acc_z[i][47:0];
         acc_x[i] = 0;
         acc_y[i] = 0;
         acc_z[i] = 0;
         pending_reads.push_back(rw);
      end else if (i < cnt) begin
         rx = longint'(req_first_x) - longint'(req_second_x);
         ry = longint'(req_first_y) - longint'(req_second_y);
         rz = longint'(req_first_z) - longint'(req_second_z);
         // squares can pass 2^63, so they are taken as unsigned
         sumsq = 68'($unsigned(rx * rx)) + 68'($unsigned(ry * ry))
                 + 68'($unsigned(rz * rz));
         span = floor_sqrt(sumsq);
         if (span != 0) begin
            rad_sum = 64'(req_first_radius);
            if (j >= cnt) begin
               rad_sum += 64'(shell_rad);
               k = shell_k;
            end else begin
               rad_sum += 64'(req_second_radius);
               k = pair_k;
            end
            fx = spring_term(k, rad_sum, rx, span);
            fy = spring_term(k, rad_sum, ry, span);
            fz = spring_term(k, rad_sum, rz, span);
            acc_x[i] = clamp_add(acc_x[i], fx);
            acc_y[i] = clamp_add(acc_y[i], fy);
            acc_z[i] = clamp_add(acc_z[i], fz);
            if (j < cnt) begin
               acc_x[j] = clamp_add(acc_x[j], -fx);
               acc_y[j] = clamp_add(acc_y[j], -fy);
               acc_z[j] = clamp_add(acc_z[j], -fz);
            end
         end
      end
   endtask

   task automatic note_mismatch(string what, logic [47:0] want, logic [47:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // results first: a word accepted on the same edge cannot be the source
   always @(posedge clock) begin
      read_word_type rw;
      if (reset) begin
         real_count = '0;
         pair_k = '0;
         shell_k = '0;
         shell_rad = '0;
         for (int n = 0; n < STORE_DEPTH; n++) begin
            acc_x[n] = 0;
            acc_y[n] = 0;
            acc_z[n] = 0;
         end
         pending_reads.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reads.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word for index %0d", rsp_particle_index);
            end else begin
               rw = pending_reads.pop_front();
               if (rsp_particle_index != rw.index)
                  note_mismatch("particle_index", 48'(rw.index), 48'(rsp_particle_index));
               if (rsp_force_x != rw.fx) note_mismatch("force_x", rw.fx, rsp_force_x);
               if (rsp_force_y != rw.fy) note_mismatch("force_y", rw.fy, rsp_force_y);
               if (rsp_force_z != rw.fz) note_mismatch("force_z", rw.fz, rsp_force_z);
            end
         end
         if (req_valid && !req_stall) predict_word();
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               sspfa_pkg::REG_COUNT: begin
                  real_count = pwdata[12:0];
               end
               sspfa_pkg::REG_PART_STIFF: begin
                  pair_k = pwdata;
               end
               sspfa_pkg::REG_SHELL_STIFF: begin
                  shell_k = pwdata;
               end
               sspfa_pkg::REG_SHELL_RADIUS: begin
                  shell_rad = pwdata[30:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   initial fail_count = 0;

endmodule
`default_nettype wire

// ----- tb/sv/soft_sphere_pair_force_accumulator_test.sv -----
// Top of the soft-sphere pair force accumulator testbench: stimulus, stalls and verdict.
`default_nettype none
module soft_sphere_pair_force_accumulator_test;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = sspfa_pkg::ACTION_ACCUM;
   logic [11:0]        req_first_index = '0;
   logic [11:0]        req_second_index = '0;
   logic signed [31:0] req_first_x = '0;
   logic signed [31:0] req_first_y = '0;
   logic signed [31:0] req_first_z = '0;
   logic signed [31:0] req_second_x = '0;
   logic signed [31:0] req_second_y = '0;
   logic signed [31:0] req_second_z = '0;
   logic [30:0]        req_first_radius = '0;
   logic [30:0]        req_second_radius = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [11:0]        rsp_particle_index;
   logic signed [47:0] rsp_force_x;
   logic signed [47:0] rsp_force_y;
   logic signed [47:0] rsp_force_z;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   int                 fail_count;
   int                 reads_due;
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   int                 stall_run = 0;
   int                 stall_mode = 0;
   logic [12:0]        cur_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   soft_sphere_pair_force_accumulator DUT (.*);

   soft_sphere_pair_force_accumulator_checker checker_i (.*);

   // result side stalls: free-flowing, random, or long holds
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(5, 60);
      end
      stall_run--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= (stall_run % 25) < 20;
      endcase
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("soft_sphere_pair_force_accumulator_test: FAIL");
         $finish;
      end
   end

   // setup, access, then idle on the configuration port
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(logic [12:0] cnt, logic [31:0] pk, logic [31:0] sk,
                                logic [30:0] sr);
      csr_write(sspfa_pkg::REG_COUNT, 32'(cnt));
      csr_write(sspfa_pkg::REG_PART_STIFF, pk);
      csr_write(sspfa_pkg::REG_SHELL_STIFF, sk);
      csr_write(sspfa_pkg::REG_SHELL_RADIUS, 32'(sr));
      cur_count = cnt;
   endtask

   // one word on the input channel, in bursts with gaps between them
   task automatic send_word(logic act, logic [11:0] fi, logic [11:0] si,
                            logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [30:0] fr, logic [30:0] sr);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_first_index <= fi;
      req_second_index <= si;
      req_first_x <= fx;
      req_first_y <= fy;
      req_first_z <= fz;
      req_second_x <= sx;
      req_second_y <= sy;
      req_second_z <= sz;
      req_first_radius <= fr;
      req_second_radius <= sr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // let the block drain before registers change
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (reads_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_index();
      if ($urandom_range(0, 7) == 0) return 12'($urandom);
      return 12'($urandom_range(0, 19));
   endfunction

   // mostly overlapping pairs near each other, some reads, some pure noise
   task automatic random_word();
      logic [31:0] fx, fy, fz;
      logic [11:0] fi;
      int          kind;
      kind = $urandom_range(0, 99);
      fi = pick_index();
      fx = $urandom;
      fy = $urandom;
      fz = $urandom;
      if (kind < 25) begin
         send_word(sspfa_pkg::ACTION_READ, fi, 12'($urandom), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
      end else if (kind < 35) begin
         send_word(1'($urandom), 12'($urandom), 12'($urandom), $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
      end else begin
         send_word(sspfa_pkg::ACTION_ACCUM, fi, pick_index(), fx, fy, fz,
                   fx + $urandom_range(0, 'h3FFFF) - 'h1FFFF,
                   fy + $urandom_range(0, 'h3FFFF) - 'h1FFFF,
                   fz + $urandom_range(0, 'h3FFFF) - 'h1FFFF,
                   31'($urandom_range(0, 'h30000)), 31'($urandom_range(0, 'h30000)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, shell pairs, coincident pair, first index not real
      set_registers(13'd8, 32'h0001_0000, 32'h0002_8000, 31'h0000_8000);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd0, 12'd1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                31'h7FFFFFFF);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd1, 12'd0, 32'h80000000, 0, 32'h7FFFFFFF,
                32'h7FFFFFFF, 0, 32'h80000000, 31'd0, 31'd0);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd2, 12'd3, 32'h10000, 32'h20000, 32'h30000,
                32'h10000, 32'h20000, 32'h30000, 31'h10000, 31'h10000);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd2, 12'd3, 32'h10000, 32'h20000, 32'h30000,
                32'h18000, 32'h20000, 32'h30000, 31'h10000, 31'h10000);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd4, 12'd8, 0, 0, 0, 32'h4000, 32'hFFFFC000,
                32'h100, 31'h8000, 31'h7FFFFFFF);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd5, 12'd4095, 32'hFFFF0000, 0, 0, 0, 0, 0,
                31'h20000, 31'd5);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd8, 12'd0, 0, 0, 0, 32'h8000, 0, 0,
                31'h10000, 31'h10000);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd4095, 12'd1, 0, 0, 0, 32'h8000, 0, 0,
                31'h10000, 31'h10000);
      send_word(sspfa_pkg::ACTION_ACCUM, 12'd6, 12'd7, 0, 0, 0, 0, 0, 1, 31'h7FFFFFFF,
                31'h7FFFFFFF);
      for (int n = 0; n < 9; n++)
         send_word(sspfa_pkg::ACTION_READ, 12'(n), 12'hFFF, 0, 0, 0, 0, 0, 0, 31'd0, 31'd0);
      send_word(sspfa_pkg::ACTION_READ, 12'd4095, 12'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
                31'h7FFFFFFF);
      send_word(sspfa_pkg::ACTION_READ, 12'd0, 12'd0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd0);
      repeat (150) random_word();

      // register settings across the range, the extremes among them
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: set_registers(13'd0, 32'd0, 32'd0, 31'd0);
            1: set_registers(13'd4096, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
            2: set_registers(13'h1FFF, 32'h0010_0000, 32'd0, 31'h7FFFFFFF);
            3: set_registers(13'd16, $urandom, $urandom, 31'($urandom));
            default: set_registers(13'd6, 32'h0001_2345, 32'hFFFFFFFF, 31'd0);
         endcase
         repeat (150) random_word();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (reads_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("soft_sphere_pair_force_accumulator_test: PASS");
      else
         $display("soft_sphere_pair_force_accumulator_test: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/sspfa_pkg.sv
hw/rtl/sspfa_ram.sv
hw/rtl/soft_sphere_pair_force_accumulator.sv
hw/rtl/sspfa_checker.sv
tb/sv/soft_sphere_pair_force_accumulator_checker.sv
tb/sv/soft_sphere_pair_force_accumulator_test.sv
